// ----- rtl/hpfa_pkg.sv -----
// ----------------------------------------------------------------------------
// hpfa_pkg
// shared types, request codes and saturation helpers of the pair force block
// ----------------------------------------------------------------------------
package hpfa_pkg;

    localparam logic [1:0] REQ_WRITE_POS = 2'd0;
    localparam logic [1:0] REQ_PAIR      = 2'd1;
    localparam logic [1:0] REQ_READ      = 2'd2;
    localparam logic [1:0] REQ_CLEAR     = 2'd3;

    localparam int IDX_W    = 10;
    localparam int CFG_W    = 11;
    localparam int VAL_W    = 32;
    localparam int FRC_W    = 48;
    localparam int ENG_W    = 63;
    localparam logic [CFG_W-1:0] BULK_RESET = 11'd1024;

    typedef struct packed {
        logic        [1:0]       req_type;
        logic        [IDX_W-1:0] atom_index;
        logic        [IDX_W-1:0] nbr_index;
        logic signed [VAL_W-1:0] vec_x;
        logic signed [VAL_W-1:0] vec_y;
        logic signed [VAL_W-1:0] vec_z;
        logic signed [VAL_W-1:0] row_x;
        logic signed [VAL_W-1:0] row_y;
        logic signed [VAL_W-1:0] row_z;
    } t_in_req;

    typedef struct packed {
        logic signed [FRC_W-1:0] force_x;
        logic signed [FRC_W-1:0] force_y;
        logic signed [FRC_W-1:0] force_z;
        logic        [ENG_W-1:0] energy;
    } t_out_res;

    typedef struct packed {
        logic disp_en;
        logic prod_en;
        logic bsum_en;
        logic bmul_en;
    } t_math_ctl;

    function automatic logic signed [VAL_W-1:0] f_sat32(input logic signed [33:0] v);
        logic signed [VAL_W-1:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(VAL_W-1){1'b1}}};
        end
        return r;
    endfunction

    // acc plus or minus d, clamped to the 48-bit signed range
    function automatic logic signed [FRC_W-1:0] f_sat48_add(
        input logic signed [FRC_W-1:0] acc,
        input logic signed [FRC_W-1:0] d,
        input logic                    sub
    );
        logic signed [FRC_W:0] s;
        logic signed [FRC_W-1:0] r;
        if (sub) begin
            s = {acc[FRC_W-1], acc} - {d[FRC_W-1], d};
        end else begin
            s = {acc[FRC_W-1], acc} + {d[FRC_W-1], d};
        end
        if (s[FRC_W] == s[FRC_W-1]) begin
            r = s[FRC_W-1:0];
        end else if (s[FRC_W]) begin
            r = {1'b1, {(FRC_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(FRC_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// ----- rtl/hpfa_ram.sv -----
// ----------------------------------------------------------------------------
// hpfa_ram
// generic simple dual-port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module hpfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/hpfa_math.sv -----
// ----------------------------------------------------------------------------
// hpfa_math
// pair arithmetic: displacement, projection b, energy term and force deltas
// ----------------------------------------------------------------------------
module hpfa_math (
    input  logic                               i_clk,
    input  hpfa_pkg::t_math_ctl                i_ctl,
    input  logic signed [hpfa_pkg::VAL_W-1:0]  i_eq_x,
    input  logic signed [hpfa_pkg::VAL_W-1:0]  i_eq_y,
    input  logic signed [hpfa_pkg::VAL_W-1:0]  i_eq_z,
    input  logic signed [hpfa_pkg::VAL_W-1:0]  i_row_x,
    input  logic signed [hpfa_pkg::VAL_W-1:0]  i_row_y,
    input  logic signed [hpfa_pkg::VAL_W-1:0]  i_row_z,
    input  logic [3*hpfa_pkg::VAL_W-1:0]       i_pos_a,
    input  logic [3*hpfa_pkg::VAL_W-1:0]       i_pos_n,
    output logic signed [hpfa_pkg::FRC_W-1:0]  o_dlt_x,
    output logic signed [hpfa_pkg::FRC_W-1:0]  o_dlt_y,
    output logic signed [hpfa_pkg::FRC_W-1:0]  o_dlt_z,
    output logic [hpfa_pkg::ENG_W-1:0]         o_bb
);
    import hpfa_pkg::*;

    logic signed [VAL_W-1:0] r_dx, r_dy, r_dz, r_b;
    logic signed [63:0]      r_px, r_py, r_pz;
    logic signed [63:0]      n_mx, n_my, n_mz, n_bb;
    logic signed [65:0]      n_sum;
    logic signed [49:0]      n_sh;
    logic signed [VAL_W-1:0] n_b;
    logic signed [FRC_W-1:0] r_fx, r_fy, r_fz;
    logic [ENG_W-1:0]        r_bb;

    function automatic logic signed [33:0] f_disp(
        input logic signed [VAL_W-1:0] e,
        input logic signed [VAL_W-1:0] pa,
        input logic signed [VAL_W-1:0] pn
    );
        return 34'(e) + 34'(pa) - 34'(pn);
    endfunction

    // floor shift of the exact sum, then clamp to q16.16
    always_comb begin
        n_sum = 66'(r_px) + 66'(r_py) + 66'(r_pz);
        n_sh  = n_sum[65:16];
        if (n_sh[49:31] == {19{1'b0}} || n_sh[49:31] == {19{1'b1}}) begin
            n_b = n_sh[31:0];
        end else if (n_sh[49]) begin
            n_b = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            n_b = {1'b0, {(VAL_W-1){1'b1}}};
        end
        n_bb = r_b * r_b;
        n_mx = r_b * i_row_x;
        n_my = r_b * i_row_y;
        n_mz = r_b * i_row_z;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.disp_en) begin
            r_dx <= f_sat32(f_disp(i_eq_x, i_pos_a[VAL_W-1:0], i_pos_n[VAL_W-1:0]));
            r_dy <= f_sat32(f_disp(i_eq_y, i_pos_a[2*VAL_W-1:VAL_W],
                                   i_pos_n[2*VAL_W-1:VAL_W]));
            r_dz <= f_sat32(f_disp(i_eq_z, i_pos_a[3*VAL_W-1:2*VAL_W],
                                   i_pos_n[3*VAL_W-1:2*VAL_W]));
        end
        if (i_ctl.prod_en) begin
            r_px <= r_dx * i_row_x;
            r_py <= r_dy * i_row_y;
            r_pz <= r_dz * i_row_z;
        end
        if (i_ctl.bsum_en) begin
            r_b <= n_b;
        end
        if (i_ctl.bmul_en) begin
            r_bb <= n_bb[ENG_W-1:0];
            r_fx <= n_mx[63:16];
            r_fy <= n_my[63:16];
            r_fz <= n_mz[63:16];
        end
    end

    assign o_dlt_x = r_fx;
    assign o_dlt_y = r_fy;
    assign o_dlt_z = r_fz;
    assign o_bb    = r_bb;
endmodule

// ----- rtl/harmonic_pair_force_accumulator.sv -----
// a position write passes S_WPOS; a pair passes S_RDA, S_RDN, S_DISP, S_PROD,
// S_BSUM, S_BMUL and S_UPA, then S_RFN and S_UPN only when the neighbor index
// is below bulk_atom_count; a clear zeroes each entry in S_CLR; a read passes S_RDF, S_ROUT
// throughput: one request at a time, set by the single read port of each store
// and the read-modify-write of one or two force entries; a read waits on a held output
// reset: synchronous, clears energy, sets bulk_atom_count to 1024 and sweeps the
// whole force store to zero while no request is taken
// ----------------------------------------------------------------------------
// harmonic_pair_force_accumulator
// per-atom positions and saturating force accumulators with harmonic pair terms
// ----------------------------------------------------------------------------
module harmonic_pair_force_accumulator #(
    parameter int MAX_ATOMS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [hpfa_pkg::CFG_W-1:0]          i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  hpfa_pkg::t_in_req                   i_in_req,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output hpfa_pkg::t_out_res                  o_out_res
);
    import hpfa_pkg::*;

    localparam int AW = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_ATOMS - 1);

    // sequencer states
    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_WPOS = 4'd2;
    localparam logic [3:0] S_RDA  = 4'd3;
    localparam logic [3:0] S_RDN  = 4'd4;
    localparam logic [3:0] S_DISP = 4'd5;
    localparam logic [3:0] S_PROD = 4'd6;
    localparam logic [3:0] S_BSUM = 4'd7;
    localparam logic [3:0] S_BMUL = 4'd8;
    localparam logic [3:0] S_UPA  = 4'd9;
    localparam logic [3:0] S_RFN  = 4'd10;
    localparam logic [3:0] S_UPN  = 4'd11;
    localparam logic [3:0] S_RDF  = 4'd12;
    localparam logic [3:0] S_ROUT = 4'd13;

    // index wrap onto the store depth, restoring subtract one bit a step
    function automatic logic [AW-1:0] f_wrap(input logic [IDX_W-1:0] v);
        logic [IDX_W-1:0] r;
        logic [26:0]      m;
        r = v;
        for (int k = IDX_W - 1; k >= 0; k--) begin
            m = 27'(MAX_ATOMS) << k;
            if (27'(r) >= m) begin
                r = r - m[IDX_W-1:0];
            end
        end
        return AW'(r);
    endfunction

    logic [3:0]        r_state, n_state;
    logic [CFG_W-1:0]  r_bulk;
    logic [AW-1:0]     r_clr_addr;
    logic [ENG_W-1:0]  r_energy;
    t_in_req           r_req;
    logic [AW-1:0]     r_a, r_n;
    logic [3*VAL_W-1:0] r_pos_a;
    t_out_res          r_res;
    logic              r_out_valid;

    logic              w_accept, w_out_free, w_bulk_n;
    logic [63:0]       w_esum;

    // memory ports
    logic               pos_re;
    logic [AW-1:0]      pos_raddr;
    logic [3*VAL_W-1:0] pos_rdata;
    logic               frc_we, frc_re;
    logic [AW-1:0]      frc_waddr, frc_raddr;
    logic [3*FRC_W-1:0] frc_wdata, frc_rdata;

    t_math_ctl               math_ctl;
    logic signed [FRC_W-1:0] dlt_x, dlt_y, dlt_z;
    logic [ENG_W-1:0]        bb;

    // take a request only from idle; a finished read may still sit in the output
    assign w_accept   = (r_state == S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_bulk_n   = {1'b0, r_req.nbr_index} < r_bulk;
    assign w_esum     = {1'b0, r_energy} + {1'b0, bb};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLR:  if (r_clr_addr == LAST_ADDR) n_state = S_IDLE;
            S_IDLE: begin
                if (w_accept) begin
                    unique case (i_in_req.req_type)
                        REQ_WRITE_POS: n_state = S_WPOS;
                        REQ_PAIR:      n_state = S_RDA;
                        REQ_READ:      n_state = S_RDF;
                        REQ_CLEAR:     n_state = S_CLR;
                        default:       n_state = S_IDLE;
                    endcase
                end
            end
            S_WPOS: n_state = S_IDLE;
            S_RDA:  n_state = S_RDN;
            S_RDN:  n_state = S_DISP;
            S_DISP: n_state = S_PROD;
            S_PROD: n_state = S_BSUM;
            S_BSUM: n_state = S_BMUL;
            S_BMUL: n_state = S_UPA;
            S_UPA:  n_state = w_bulk_n ? S_RFN : S_IDLE;
            S_RFN:  n_state = S_UPN;
            S_UPN:  n_state = S_IDLE;
            S_RDF:  n_state = S_ROUT;
            S_ROUT: if (w_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // memory and datapath controls
    always_comb begin
        pos_re    = (r_state == S_RDA) || (r_state == S_RDN);
        pos_raddr = (r_state == S_RDN) ? r_n : r_a;

        frc_re    = (r_state == S_BMUL) || (r_state == S_RFN) || (r_state == S_RDF);
        frc_raddr = (r_state == S_RFN) ? r_n : r_a;

        frc_we    = 1'b0;
        frc_waddr = r_a;
        frc_wdata = '0;
        unique case (r_state)
            S_CLR: begin
                frc_we    = 1'b1;
                frc_waddr = r_clr_addr;
            end
            S_UPA: begin
                frc_we    = 1'b1;
                frc_wdata = {f_sat48_add(frc_rdata[3*FRC_W-1:2*FRC_W], dlt_z, 1'b1),
                             f_sat48_add(frc_rdata[2*FRC_W-1:FRC_W], dlt_y, 1'b1),
                             f_sat48_add(frc_rdata[FRC_W-1:0], dlt_x, 1'b1)};
            end
            S_UPN: begin
                frc_we    = 1'b1;
                frc_waddr = r_n;
                frc_wdata = {f_sat48_add(frc_rdata[3*FRC_W-1:2*FRC_W], dlt_z, 1'b0),
                             f_sat48_add(frc_rdata[2*FRC_W-1:FRC_W], dlt_y, 1'b0),
                             f_sat48_add(frc_rdata[FRC_W-1:0], dlt_x, 1'b0)};
            end
            default: begin
            end
        endcase

        math_ctl.disp_en = (r_state == S_DISP);
        math_ctl.prod_en = (r_state == S_PROD);
        math_ctl.bsum_en = (r_state == S_BSUM);
        math_ctl.bmul_en = (r_state == S_BMUL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_bulk      <= BULK_RESET;
            r_clr_addr  <= '0;
            r_energy    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bulk <= i_cfg_wdata;
            end
            // clear request restarts the sweep and zeroes energy at once
            if (w_accept && i_in_req.req_type == REQ_CLEAR) begin
                r_clr_addr <= '0;
                r_energy   <= '0;
            end else if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            // energy saturates at the top of its 63-bit range
            if (r_state == S_UPA) begin
                r_energy <= w_esum[63] ? {ENG_W{1'b1}} : w_esum[ENG_W-1:0];
            end
            if (r_state == S_ROUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // request capture and result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_req;
            r_a   <= f_wrap(i_in_req.atom_index);
            r_n   <= f_wrap(i_in_req.nbr_index);
        end
        if (r_state == S_RDN) begin
            r_pos_a <= pos_rdata;
        end
        if (r_state == S_ROUT && w_out_free) begin
            r_res.force_x <= frc_rdata[FRC_W-1:0];
            r_res.force_y <= frc_rdata[2*FRC_W-1:FRC_W];
            r_res.force_z <= frc_rdata[3*FRC_W-1:2*FRC_W];
            r_res.energy  <= r_energy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_res   = r_res;

    // positions, x in the low word
    hpfa_ram #(
        .WIDTH (3 * VAL_W),
        .DEPTH (MAX_ATOMS)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_WPOS),
        .i_waddr (r_a),
        .i_wdata ({r_req.vec_z, r_req.vec_y, r_req.vec_x}),
        .i_re    (pos_re),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    // force accumulators, x in the low word
    hpfa_ram #(
        .WIDTH (3 * FRC_W),
        .DEPTH (MAX_ATOMS)
    ) u_frc_ram (
        .i_clk   (i_clk),
        .i_we    (frc_we),
        .i_waddr (frc_waddr),
        .i_wdata (frc_wdata),
        .i_re    (frc_re),
        .i_raddr (frc_raddr),
        .o_rdata (frc_rdata)
    );

    hpfa_math u_math (
        .i_clk   (i_clk),
        .i_ctl   (math_ctl),
        .i_eq_x  (r_req.vec_x),
        .i_eq_y  (r_req.vec_y),
        .i_eq_z  (r_req.vec_z),
        .i_row_x (r_req.row_x),
        .i_row_y (r_req.row_y),
        .i_row_z (r_req.row_z),
        .i_pos_a (r_pos_a),
        .i_pos_n (pos_rdata),
        .o_dlt_x (dlt_x),
        .o_dlt_y (dlt_y),
        .o_dlt_z (dlt_z),
        .o_bb    (bb)
    );
endmodule
